[src/bdpb_pkg.sv]
// ----------------------------------------------------------------------------
// bdpb_pkg
// shared types and constants of the brush dab pixel blend
// ----------------------------------------------------------------------------
package bdpb_pkg;

	localparam int SIZE_BITS     = 10;
	localparam int CHAN_BITS     = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 10;
	localparam int QUO_BITS      = 9;
	localparam int REP_BITS      = 24;
	localparam int NUM_COLORS    = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BRUSH_SIZE  = 3'd0,
		REG_OPACITY     = 3'd1,
		REG_HARDNESS    = 3'd2,
		REG_PAINT_RED   = 3'd3,
		REG_PAINT_GREEN = 3'd4,
		REG_PAINT_BLUE  = 3'd5,
		REG_ERASER_MODE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} rgba_t;

	// valid bit plus per-item hit flag travelling between the sections
	typedef struct packed {
		logic valid;
		logic hit;
	} ctl_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] brush_size;
		logic [CHAN_BITS-1:0] opacity;
		logic [CHAN_BITS-1:0] hardness;
		logic [CHAN_BITS-1:0] paint_red;
		logic [CHAN_BITS-1:0] paint_green;
		logic [CHAN_BITS-1:0] paint_blue;
		logic                 eraser_mode;
	} cfg_t;

	typedef struct packed {
		rgba_t pix;
		logic  changed;
	} res_item_t;

	localparam cfg_t CFG_RESET = '{
		brush_size:  10'd32,
		opacity:     8'd191,
		hardness:    8'd77,
		paint_red:   8'd0,
		paint_green: 8'd0,
		paint_blue:  8'd0,
		eraser_mode: 1'b0
	};

endpackage

[src/bdpb_pix_if.sv]
// ----------------------------------------------------------------------------
// bdpb_pix_if
// pixel item channel: dab centre, pixel position and destination rgba
// ----------------------------------------------------------------------------
interface bdpb_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [7:0]            dst_red;
	logic [7:0]            dst_green;
	logic [7:0]            dst_blue;
	logic [7:0]            dst_alpha;

	modport source (
		output valid, center_x, center_y, pixel_x, pixel_y,
		output dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, pixel_x, pixel_y,
		input  dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);
endinterface

[src/bdpb_res_if.sv]
// ----------------------------------------------------------------------------
// bdpb_res_if
// result item channel: new rgba and changed flag
// ----------------------------------------------------------------------------
interface bdpb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       changed;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha, changed,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha, changed,
		output ready
	);
endinterface

[src/bdpb_cfg_if.sv]
// ----------------------------------------------------------------------------
// bdpb_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface bdpb_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

[src/brush_dab_pixel_blend.sv]
// ----------------------------------------------------------------------------
// brush_dab_pixel_blend
// soft round brush dab, one pixel per item, alpha-over or eraser blend
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the result buffer has room and returns
// exactly one result item per pixel, in order. The pipeline holds the square
// root (one bit per stage, 10+FRAC_BITS stages), the distance-over-radius and
// hardness divides (FRAC_BITS+1 stages each) and the nine-stage rounding
// divide of the colour blend. A two-entry result buffer sits at the output, so
// pixels keep flowing while a result waits; the pipeline only stalls when both
// entries are full. Registers are written over the cfg channel (always ready)
// and must only change while no pixel is in flight. Pixels outside the radius
// or with zero coverage come back unchanged with changed low.
// ----------------------------------------------------------------------------
module brush_dab_pixel_blend import bdpb_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	bdpb_pix_if.sink   pixel,
	bdpb_res_if.source result,
	bdpb_cfg_if.sink   cfg
);
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// register file
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_BRUSH_SIZE:  cfg_q.brush_size  <= cfg.data[SIZE_BITS-1:0];
				REG_OPACITY:     cfg_q.opacity     <= cfg.data[7:0];
				REG_HARDNESS:    cfg_q.hardness    <= cfg.data[7:0];
				REG_PAINT_RED:   cfg_q.paint_red   <= cfg.data[7:0];
				REG_PAINT_GREEN: cfg_q.paint_green <= cfg.data[7:0];
				REG_PAINT_BLUE:  cfg_q.paint_blue  <= cfg.data[7:0];
				REG_ERASER_MODE: cfg_q.eraser_mode <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// derived constants: x/255 in binary is the byte x repeated, full scale is one
	logic [REP_BITS-1:0]    rep_h, rep_o;
	logic [FRAC_BITS:0]     hard_q, opac_q;
	logic [2*SIZE_BITS-1:0] size_sq_q;

	assign rep_h = {3{cfg_q.hardness}};
	assign rep_o = {3{cfg_q.opacity}};

	always_ff @(posedge clk) begin
		hard_q    <= (cfg_q.hardness == 8'hFF) ? ONE
		             : {1'b0, rep_h[REP_BITS-1 -: FRAC_BITS]};
		opac_q    <= (cfg_q.opacity == 8'hFF) ? ONE
		             : {1'b0, rep_o[REP_BITS-1 -: FRAC_BITS]};
		size_sq_q <= cfg_q.brush_size * cfg_q.brush_size;
	end

	// pipeline advance: held only while the result buffer is full
	logic [1:0] cnt_q;
	logic       en;

	assign en          = (cnt_q != 2'd2);
	assign pixel.ready = en;

	rgba_t dst_in;

	assign dst_in = '{red: pixel.dst_red, green: pixel.dst_green,
	                  blue: pixel.dst_blue, alpha: pixel.dst_alpha};

	// distance and square root
	ctl_t                           dist_ctl;
	logic [SIZE_BITS+FRAC_BITS-1:0] dist_root;
	rgba_t                          dist_px;

	bdpb_dist #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pixel.valid),
		.center_x (pixel.center_x),
		.center_y (pixel.center_y),
		.pixel_x  (pixel.pixel_x),
		.pixel_y  (pixel.pixel_y),
		.dst      (dst_in),
		.size_sq  (size_sq_q),
		.ctl      (dist_ctl),
		.root     (dist_root),
		.dst_o    (dist_px)
	);

	// falloff and coverage
	ctl_t               fall_ctl;
	logic [FRAC_BITS:0] fall_cover;
	rgba_t              fall_px;

	bdpb_falloff #(
		.FRAC_BITS (FRAC_BITS)
	) u_falloff (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_i      (dist_ctl),
		.root       (dist_root),
		.dst        (dist_px),
		.brush_size (cfg_q.brush_size),
		.hard_q     (hard_q),
		.opac_q     (opac_q),
		.ctl_o      (fall_ctl),
		.cov        (fall_cover),
		.dst_o      (fall_px)
	);

	// blend
	ctl_t  blend_ctl;
	rgba_t blend_res;

	bdpb_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (fall_ctl),
		.cov    (fall_cover),
		.dst    (fall_px),
		.cfg    (cfg_q),
		.ctl_o  (blend_ctl),
		.res    (blend_res)
	);

	// two-entry result buffer
	res_item_t buf_q [2];
	logic      wr_q, rd_q;
	logic      push, pop;

	assign push = en && blend_ctl.valid;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{pix: blend_res, changed: blend_ctl.hit};
		end
	end

	assign result.valid     = (cnt_q != 2'd0);
	assign result.out_red   = buf_q[rd_q].pix.red;
	assign result.out_green = buf_q[rd_q].pix.green;
	assign result.out_blue  = buf_q[rd_q].pix.blue;
	assign result.out_alpha = buf_q[rd_q].pix.alpha;
	assign result.changed   = buf_q[rd_q].changed;

endmodule

[src/bdpb_dist.sv]
// ----------------------------------------------------------------------------
// bdpb_dist
// half-pixel offsets, squared distance, radius test and pipelined square root
// ----------------------------------------------------------------------------
module bdpb_dist import bdpb_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [COORD_BITS-1:0]          center_x,
	input  logic [COORD_BITS-1:0]          center_y,
	input  logic [COORD_BITS-1:0]          pixel_x,
	input  logic [COORD_BITS-1:0]          pixel_y,
	input  rgba_t                          dst,
	input  logic [2*SIZE_BITS-1:0]         size_sq,
	output ctl_t                           ctl,
	output logic [SIZE_BITS+FRAC_BITS-1:0] root,
	output rgba_t                          dst_o
);
	localparam int OW  = COORD_BITS + 2;
	localparam int SQW = 2*COORD_BITS + 3;
	localparam int DW  = 2*SIZE_BITS;
	localparam int RN  = SIZE_BITS + FRAC_BITS;
	localparam int RW  = RN + 3;

	// stage 1: offsets in half pixels
	logic [COORD_BITS:0]    dx, dy;
	logic signed [OW-1:0]   ex_s1, ey_s1;
	logic                   v_s1;
	rgba_t                  px_s1;

	assign dx = {1'b0, pixel_x} - {1'b0, center_x};
	assign dy = {1'b0, pixel_y} - {1'b0, center_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= {dx, 1'b1};
			ey_s1 <= {dy, 1'b1};
			px_s1 <= dst;
		end
	end

	// stage 2: squares
	logic signed [2*OW-1:0] mx, my;
	logic [SQW-1:0]         sqx_s2, sqy_s2;
	logic                   v_s2;
	rgba_t                  px_s2;

	assign mx = ex_s1 * ex_s1;
	assign my = ey_s1 * ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= mx[SQW-1:0];
			sqy_s2 <= my[SQW-1:0];
			px_s2  <= px_s1;
		end
	end

	// stage 3: sum and radius test, feeds the root pipe
	logic [SQW:0]    dsum;
	logic            in_rad;

	assign dsum   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign in_rad = dsum <= (SQW+1)'(size_sq);

	logic [RW-1:0] rt_rem_s  [RN+1];
	logic [RN-1:0] rt_root_s [RN+1];
	logic [DW-1:0] rt_d_s    [RN+1];
	logic          rt_v_s    [RN+1];
	logic          rt_hit_s  [RN+1];
	rgba_t         rt_px_s   [RN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			rt_d_s[0]    <= dsum[DW-1:0];
			rt_hit_s[0]  <= in_rad;
			rt_px_s[0]   <= px_s2;
		end
	end

	// one root bit per stage, most significant first
	for (genvar k = 0; k < RN; k++) begin : g_root
		localparam int I = RN - 1 - k;
		logic [1:0]    pair;
		logic [RW-1:0] rem_n, trial;

		if (I >= FRAC_BITS) begin : g_pair
			assign pair = rt_d_s[k][2*(I-FRAC_BITS) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign rem_n = {rt_rem_s[k][RW-3:0], pair};
		assign trial = {1'b0, rt_root_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_n >= trial) begin
					rt_rem_s[k+1]  <= rem_n - trial;
					rt_root_s[k+1] <= {rt_root_s[k][RN-2:0], 1'b1};
				end else begin
					rt_rem_s[k+1]  <= rem_n;
					rt_root_s[k+1] <= {rt_root_s[k][RN-2:0], 1'b0};
				end
				rt_d_s[k+1]   <= rt_d_s[k];
				rt_hit_s[k+1] <= rt_hit_s[k];
				rt_px_s[k+1]  <= rt_px_s[k];
			end
		end
	end

	assign ctl   = '{valid: rt_v_s[RN], hit: rt_hit_s[RN]};
	assign root  = rt_root_s[RN];
	assign dst_o = rt_px_s[RN];

endmodule

[src/bdpb_falloff.sv]
// ----------------------------------------------------------------------------
// bdpb_falloff
// distance over radius, hardness falloff divide and opacity scaling
// ----------------------------------------------------------------------------
module bdpb_falloff import bdpb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  ctl_t                           ctl_i,
	input  logic [SIZE_BITS+FRAC_BITS-1:0] root,
	input  rgba_t                          dst,
	input  logic [SIZE_BITS-1:0]           brush_size,
	input  logic [FRAC_BITS:0]             hard_q,
	input  logic [FRAC_BITS:0]             opac_q,
	output ctl_t                           ctl_o,
	output logic [FRAC_BITS:0]             cov,
	output rgba_t                          dst_o
);
	localparam int RN = SIZE_BITS + FRAC_BITS;
	localparam int Q  = FRAC_BITS + 1;
	localparam int FW = 2*FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// t = root / size, restoring division
	logic [RN-1:0] td_rem_s [Q];
	logic [Q-1:0]  td_q_s   [Q];
	logic          td_v_s   [Q];
	logic          td_hit_s [Q];
	rgba_t         td_px_s  [Q];

	for (genvar k = 0; k < Q; k++) begin : g_tdiv
		localparam int J = FRAC_BITS - k;
		logic [RN-1:0] src_rem, dv;
		logic [Q-1:0]  src_q;
		logic          src_v, src_hit, ge;
		rgba_t         src_px;

		if (k == 0) begin : g_first
			assign src_rem = root;
			assign src_q   = '0;
			assign src_v   = ctl_i.valid;
			assign src_hit = ctl_i.hit;
			assign src_px  = dst;
		end else begin : g_next
			assign src_rem = td_rem_s[k-1];
			assign src_q   = td_q_s[k-1];
			assign src_v   = td_v_s[k-1];
			assign src_hit = td_hit_s[k-1];
			assign src_px  = td_px_s[k-1];
		end

		assign dv = {{(RN-SIZE_BITS){1'b0}}, brush_size} << J;
		assign ge = src_rem >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				td_v_s[k] <= 1'b0;
			end else if (en) begin
				td_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				td_rem_s[k] <= ge ? src_rem - dv : src_rem;
				td_q_s[k]   <= {src_q[Q-2:0], ge};
				td_hit_s[k] <= src_hit;
				td_px_s[k]  <= src_px;
			end
		end
	end

	// falloff setup: clip, compare with hardness, numerator and denominator
	logic [Q-1:0] tc;
	logic [Q-1:0] num_su, den_su;
	logic         gt_su, v_su, hit_su;
	rgba_t        px_su;

	assign tc = (td_q_s[Q-1] > ONE) ? ONE : td_q_s[Q-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_su <= 1'b0;
		end else if (en) begin
			v_su <= td_v_s[Q-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gt_su  <= tc > hard_q;
			num_su <= tc - hard_q;
			den_su <= ONE - hard_q;
			hit_su <= td_hit_s[Q-1];
			px_su  <= td_px_s[Q-1];
		end
	end

	// (t - h) * ONE / (ONE - h)
	logic [FW-1:0] fd_rem_s [Q];
	logic [Q-1:0]  fd_den_s [Q];
	logic [Q-1:0]  fd_q_s   [Q];
	logic          fd_gt_s  [Q];
	logic          fd_v_s   [Q];
	logic          fd_hit_s [Q];
	rgba_t         fd_px_s  [Q];

	for (genvar k = 0; k < Q; k++) begin : g_fdiv
		localparam int J = FRAC_BITS - k;
		logic [FW-1:0] src_rem, dv;
		logic [Q-1:0]  src_den, src_q;
		logic          src_gt, src_v, src_hit, ge;
		rgba_t         src_px;

		if (k == 0) begin : g_first
			assign src_rem = {num_su, {FRAC_BITS{1'b0}}};
			assign src_den = den_su;
			assign src_q   = '0;
			assign src_gt  = gt_su;
			assign src_v   = v_su;
			assign src_hit = hit_su;
			assign src_px  = px_su;
		end else begin : g_next
			assign src_rem = fd_rem_s[k-1];
			assign src_den = fd_den_s[k-1];
			assign src_q   = fd_q_s[k-1];
			assign src_gt  = fd_gt_s[k-1];
			assign src_v   = fd_v_s[k-1];
			assign src_hit = fd_hit_s[k-1];
			assign src_px  = fd_px_s[k-1];
		end

		assign dv = {{(FW-Q){1'b0}}, src_den} << J;
		assign ge = src_rem >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fd_v_s[k] <= 1'b0;
			end else if (en) begin
				fd_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				fd_rem_s[k] <= ge ? src_rem - dv : src_rem;
				fd_den_s[k] <= src_den;
				fd_q_s[k]   <= {src_q[Q-2:0], ge};
				fd_gt_s[k]  <= src_gt;
				fd_hit_s[k] <= src_hit;
				fd_px_s[k]  <= src_px;
			end
		end
	end

	// falloff times opacity
	logic [Q-1:0]     fall;
	logic [2*Q-1:0]   prod;
	logic [Q-1:0]     a_sm;
	logic             v_sm, hit_sm;
	rgba_t            px_sm;

	assign fall = fd_gt_s[Q-1] ? ONE - fd_q_s[Q-1] : ONE;
	assign prod = opac_q * fall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (en) begin
			v_sm <= fd_v_s[Q-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_sm   <= prod[2*FRAC_BITS:FRAC_BITS];
			hit_sm <= fd_hit_s[Q-1];
			px_sm  <= fd_px_s[Q-1];
		end
	end

	assign ctl_o = '{valid: v_sm, hit: hit_sm};
	assign cov   = a_sm;
	assign dst_o = px_sm;

endmodule

[src/bdpb_blend.sv]
// ----------------------------------------------------------------------------
// bdpb_blend
// alpha-over or eraser blend with rounding divide per colour channel
// ----------------------------------------------------------------------------
module bdpb_blend import bdpb_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_i,
	input  logic [FRAC_BITS:0] cov,
	input  rgba_t              dst,
	input  cfg_t               cfg,
	output ctl_t               ctl_o,
	output rgba_t              res
);
	localparam int AW = FRAC_BITS + 1;
	localparam int PW = FRAC_BITS + 9;
	localparam int NW = FRAC_BITS + 17;
	localparam int OW = FRAC_BITS + 8;
	localparam int DW = FRAC_BITS + 18;
	localparam int VW = FRAC_BITS + 9;
	localparam logic [AW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);

	logic [7:0] pc [NUM_COLORS];
	logic [7:0] dc [NUM_COLORS];

	assign pc[0] = cfg.paint_red;
	assign pc[1] = cfg.paint_green;
	assign pc[2] = cfg.paint_blue;
	assign dc[0] = dst.red;
	assign dc[1] = dst.green;
	assign dc[2] = dst.blue;

	// b1: partial products
	logic [AW-1:0] inv;
	logic [PW-1:0] pa_b1 [NUM_COLORS];
	logic [15:0]   cd_b1 [NUM_COLORS];
	logic [PW-1:0] a255_b1, dainv_b1;
	logic [AW-1:0] inv_b1;
	logic          v_b1, chg_b1;
	rgba_t         px_b1;

	assign inv = ONE - cov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (en) begin
			v_b1 <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_COLORS; c++) begin
				pa_b1[c] <= PW'(pc[c] * cov);
				cd_b1[c] <= dc[c] * dst.alpha;
			end
			a255_b1  <= {cov, 8'd0} - {8'd0, cov};
			dainv_b1 <= PW'(dst.alpha * inv);
			inv_b1   <= inv;
			chg_b1   <= ctl_i.hit && (cov != '0);
			px_b1    <= dst;
		end
	end

	// b2: numerators and output alpha before rounding
	logic [NW-1:0] n_b2 [NUM_COLORS];
	logic [OW-1:0] oa_b2;
	logic [PW-1:0] dainv_b2;
	logic [PW:0]   oa_sum;
	logic          v_b2, chg_b2;
	rgba_t         px_b2;

	assign oa_sum = {1'b0, a255_b1} + {1'b0, dainv_b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b2 <= 1'b0;
		end else if (en) begin
			v_b2 <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_COLORS; c++) begin
				n_b2[c] <= ({pa_b1[c], 8'd0} - NW'(pa_b1[c])) + NW'(cd_b1[c] * inv_b1);
			end
			oa_b2    <= oa_sum[OW-1:0];
			dainv_b2 <= dainv_b1;
			chg_b2   <= chg_b1;
			px_b2    <= px_b1;
		end
	end

	// b3: divider operands, rounded alpha
	logic [VW-1:0] ea_sum, pa_sum;
	logic [DW-1:0] dd_b3 [NUM_COLORS];
	logic [VW-1:0] dv_b3;
	logic [7:0]    alpha_b3;
	logic          v_b3, chg_b3;
	rgba_t         px_b3;

	assign ea_sum = dainv_b2 + HALF;
	assign pa_sum = {1'b0, oa_b2} + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b3 <= 1'b0;
		end else if (en) begin
			v_b3 <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_COLORS; c++) begin
				dd_b3[c] <= {n_b2[c], 1'b0} + DW'(oa_b2);
			end
			dv_b3    <= {oa_b2, 1'b0};
			alpha_b3 <= cfg.eraser_mode ? ea_sum[FRAC_BITS +: 8] : pa_sum[FRAC_BITS +: 8];
			chg_b3   <= chg_b2;
			px_b3    <= px_b2;
		end
	end

	// rounding divide, one quotient bit per stage
	logic [DW-1:0]       dq_rem_s [QUO_BITS][NUM_COLORS];
	logic [QUO_BITS-1:0] dq_q_s   [QUO_BITS][NUM_COLORS];
	logic [VW-1:0]       dq_dv_s  [QUO_BITS];
	logic [7:0]          dq_a_s   [QUO_BITS];
	logic                dq_v_s   [QUO_BITS];
	logic                dq_chg_s [QUO_BITS];
	rgba_t               dq_px_s  [QUO_BITS];

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		localparam int J = QUO_BITS - 1 - k;
		logic [DW-1:0]       src_rem [NUM_COLORS];
		logic [QUO_BITS-1:0] src_q   [NUM_COLORS];
		logic [VW-1:0]       src_dv;
		logic [DW-1:0]       dvs;
		logic [7:0]          src_a;
		logic                src_v, src_chg;
		rgba_t               src_px;

		if (k == 0) begin : g_first
			for (genvar c = 0; c < NUM_COLORS; c++) begin : g_ch
				assign src_rem[c] = dd_b3[c];
				assign src_q[c]   = '0;
			end
			assign src_dv  = dv_b3;
			assign src_a   = alpha_b3;
			assign src_v   = v_b3;
			assign src_chg = chg_b3;
			assign src_px  = px_b3;
		end else begin : g_next
			for (genvar c = 0; c < NUM_COLORS; c++) begin : g_ch
				assign src_rem[c] = dq_rem_s[k-1][c];
				assign src_q[c]   = dq_q_s[k-1][c];
			end
			assign src_dv  = dq_dv_s[k-1];
			assign src_a   = dq_a_s[k-1];
			assign src_v   = dq_v_s[k-1];
			assign src_chg = dq_chg_s[k-1];
			assign src_px  = dq_px_s[k-1];
		end

		assign dvs = DW'(src_dv) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dq_v_s[k] <= 1'b0;
			end else if (en) begin
				dq_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < NUM_COLORS; c++) begin
					if (src_rem[c] >= dvs) begin
						dq_rem_s[k][c] <= src_rem[c] - dvs;
						dq_q_s[k][c]   <= {src_q[c][QUO_BITS-2:0], 1'b1};
					end else begin
						dq_rem_s[k][c] <= src_rem[c];
						dq_q_s[k][c]   <= {src_q[c][QUO_BITS-2:0], 1'b0};
					end
				end
				dq_dv_s[k]  <= src_dv;
				dq_a_s[k]   <= src_a;
				dq_chg_s[k] <= src_chg;
				dq_px_s[k]  <= src_px;
			end
		end
	end

	// output select
	localparam int L = QUO_BITS - 1;
	logic  v_so, chg_so;
	rgba_t res_so;
	logic  paint;

	assign paint = dq_chg_s[L] && !cfg.eraser_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (en) begin
			v_so <= dq_v_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_so.red   <= paint ? dq_q_s[L][0][7:0] : dq_px_s[L].red;
			res_so.green <= paint ? dq_q_s[L][1][7:0] : dq_px_s[L].green;
			res_so.blue  <= paint ? dq_q_s[L][2][7:0] : dq_px_s[L].blue;
			res_so.alpha <= dq_chg_s[L] ? dq_a_s[L] : dq_px_s[L].alpha;
			chg_so       <= dq_chg_s[L];
		end
	end

	assign ctl_o = '{valid: v_so, hit: chg_so};
	assign res   = res_so;

endmodule

[src/bdpb_checker.sv]
// ----------------------------------------------------------------------------
// bdpb_checker
// port-level checks of the brush dab pixel blend
// ----------------------------------------------------------------------------
module bdpb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready,
	input logic cfg_valid,
	input logic cfg_ready
);
	// a waiting result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before taken");

	// input only backs off while results are buffered
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
		else $error("input stalled with empty result buffer");

	// register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

endmodule

bind brush_dab_pixel_blend bdpb_checker u_bdpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixel.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
